// ===== src/rgbc_pkg.sv =====
package rgbc_pkg;

  localparam int MaxWidth = 2048;
  localparam int AddrW    = $clog2(MaxWidth);
  localparam int CntW     = AddrW + 1;
  localparam int Taps     = 9;
  localparam int TapW     = $clog2(Taps);
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 48;

  localparam logic [CfgIdxW-1:0] CfgKernLeft  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgKernMid   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgKernRight = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgScale     = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgWidth     = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgHeight    = 3'd5;

  localparam logic [47:0]     KernReset   = 48'h0100_0100_0100;
  localparam logic [15:0]     ScaleReset  = 16'd7282;
  localparam logic [CntW-1:0] WidthReset  = 12'd640;
  localparam logic [15:0]     HeightReset = 16'd480;

  localparam logic [TapW-1:0] TapLast = TapW'(Taps - 1);

  typedef struct packed {
    logic       action;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       last_of_step;
    logic       end_of_frame;
  } out_word_t;

  typedef enum logic [1:0] {
    NbKeep  = 2'd0,
    NbWin   = 2'd1,
    NbShift = 2'd2
  } nb_sel_e;

  typedef struct packed {
    logic             pix_load;
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic             col_zero;
    logic             row_zero;
    nb_sel_e          nb_sel;
    logic             drd_load;
    logic [1:0]       drd_col;
    logic             acc_clr;
    logic             mac_en;
    logic [TapW-1:0]  tap;
    logic             scl_en;
    logic             out_load;
    logic             out_last;
    logic             out_eof;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

// ===== src/rgb_convolution_3x3_clamped_top.sv =====
// 3x3 RGB convolution with clamp-to-edge borders.
// Input channel: in_valid_i / in_stall_o / in_data_i. A word with action 0
// carries a pixel in raster order; action 1 is a drain tick that flushes one
// result of the frame's last row. Output channel: out_valid_o / out_stall_i /
// out_data_o, one filtered pixel per word, flagged last_of_step on the final
// result of an input word and end_of_frame on the frame's last pixel.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i (kernel
// columns, scale, width, height). The user must write them only while the
// block is idle; the block itself does not enforce it. Throughput: one input
// word at a time; the next is taken when the block is idle again. A pixel with
// one result updates the line store, runs the nine-step multiply-accumulate
// loop over the window plus the scale multiply and loads the output; a pixel
// with no result only updates the store, a row-end pixel with two results runs
// the loop twice and a drain tick first makes its three line-store reads.
// Reset restores the register defaults and clears counters and window; the
// line store holds no defined data until rows are written.
// While the receiver stalls the output word is held; the block goes on taking
// and processing input words until its next result is ready, then waits.
module rgb_convolution_3x3_clamped_top import rgbc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_word_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_word_t           out_data_o
);

  cmd_t  cmd;
  stat_t stat;

  rgbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_data_i.action),
    .in_stall_o  (in_stall_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rgbc_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  a_pixel_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !in_data_i.action |=> in_stall_o)
    else $error("pixel word did not start a store update");

  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.end_of_frame |-> out_data_o.last_of_step)
    else $error("end of frame on a word that is not last");

  a_single_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr_en |-> !cmd.rd_en)
    else $error("line store read and written in one cycle");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> stat.out_free)
    else $error("output word overwritten while stalled");

endmodule

// ===== src/rgbc_ctrl.sv =====
module rgbc_ctrl import rgbc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_action_i,
  output logic                in_stall_o,
  input  stat_t               stat_i,
  output cmd_t                cmd_o
);

  typedef enum logic [6:0] {
    SIdle = 7'b0000001,
    SPrd  = 7'b0000010,
    SDrd  = 7'b0000100,
    SLoad = 7'b0001000,
    SMac  = 7'b0010000,
    SScl  = 7'b0100000,
    SOut  = 7'b1000000
  } state_e;

  typedef enum logic [1:0] {
    ModeA = 2'd0,
    ModeB = 2'd1,
    ModeD = 2'd2
  } mode_e;

  state_e           state_q, state_d;
  mode_e            mode_q, mode_d;
  logic [CntW-1:0]  fw_q;
  logic [15:0]      fh_q;
  logic [AddrW-1:0] col_q, col_d;
  logic [15:0]      row_q, row_d;
  logic [CntW-1:0]  pend_q, pend_d;
  logic [1:0]       j_q, j_d;
  logic [TapW-1:0]  tap_q, tap_d;
  logic             needb_q, needb_d;
  logic             eof_q, eof_d;

  logic [CntW-1:0]  weff, wm1;
  logic [15:0]      hm1;
  logic             lastcol, rowlast, e1, e2;
  logic [AddrW-1:0] cl, cr;

  always_comb begin
    if (fw_q == '0) begin
      weff = CntW'(1);
    end else if (fw_q > CntW'(MaxWidth)) begin
      weff = CntW'(MaxWidth);
    end else begin
      weff = fw_q;
    end
    wm1     = weff - CntW'(1);
    hm1     = (fh_q == '0) ? 16'd0 : fh_q - 16'd1;
    lastcol = {1'b0, col_q} >= wm1;
    rowlast = row_q >= hm1;
    e1      = (col_q != '0) && (row_q != '0);
    e2      = lastcol && (row_q != '0);
    cl      = (col_q == '0) ? col_q : col_q - AddrW'(1);
    cr      = (({1'b0, col_q} + CntW'(1)) < weff) ? col_q + AddrW'(1) : col_q;
  end

  assign in_stall_o = (state_q != SIdle);

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    col_d   = col_q;
    row_d   = row_q;
    pend_d  = pend_q;
    j_d     = j_q;
    tap_d   = tap_q;
    needb_d = needb_q;
    eof_d   = eof_q;
    cmd_o   = '0;
    cmd_o.nb_sel = NbKeep;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.pix_load = 1'b1;
          if (in_action_i) begin
            if (pend_q != '0) begin
              j_d     = 2'd0;
              state_d = SDrd;
            end
          end else begin
            cmd_o.rd_en   = 1'b1;
            cmd_o.rd_addr = (pend_q != '0) ? '0 : col_q;
            // a pixel during the drain drops the pending row
            if (pend_q != '0) begin
              pend_d = '0;
              col_d  = '0;
              row_d  = '0;
            end
            state_d = SPrd;
          end
        end
      end
      SPrd: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_addr  = col_q;
        cmd_o.col_zero = (col_q == '0);
        cmd_o.row_zero = (row_q == '0);
        if (lastcol) begin
          col_d = '0;
          if (rowlast) begin
            row_d  = '0;
            pend_d = weff;
          end else begin
            row_d = row_q + 16'd1;
          end
        end else begin
          col_d = col_q + AddrW'(1);
        end
        if (e1) begin
          mode_d  = ModeA;
          needb_d = e2;
          state_d = SLoad;
        end else if (e2) begin
          mode_d  = ModeB;
          needb_d = 1'b0;
          state_d = SLoad;
        end else begin
          state_d = SIdle;
        end
      end
      SDrd: begin
        cmd_o.rd_en = (j_q != 2'd3);
        unique case (j_q)
          2'd0:    cmd_o.rd_addr = cl;
          2'd1:    cmd_o.rd_addr = col_q;
          default: cmd_o.rd_addr = cr;
        endcase
        if (j_q != 2'd0) begin
          cmd_o.drd_load = 1'b1;
          cmd_o.drd_col  = j_q - 2'd1;
        end
        j_d = j_q + 2'd1;
        if (j_q == 2'd3) begin
          pend_d  = pend_q - CntW'(1);
          eof_d   = (pend_q == CntW'(1));
          col_d   = (pend_q == CntW'(1)) ? '0 : col_q + AddrW'(1);
          mode_d  = ModeD;
          needb_d = 1'b0;
          state_d = SLoad;
        end
      end
      SLoad: begin
        cmd_o.acc_clr = 1'b1;
        unique case (mode_q)
          ModeA:   cmd_o.nb_sel = NbWin;
          ModeB:   cmd_o.nb_sel = NbShift;
          default: cmd_o.nb_sel = NbKeep;
        endcase
        tap_d   = '0;
        state_d = SMac;
      end
      SMac: begin
        cmd_o.mac_en = 1'b1;
        cmd_o.tap    = tap_q;
        tap_d        = tap_q + TapW'(1);
        if (tap_q == TapLast) begin
          state_d = SScl;
        end
      end
      SScl: begin
        cmd_o.scl_en = 1'b1;
        state_d      = SOut;
      end
      SOut: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = (mode_q != ModeA) || !needb_q;
          cmd_o.out_eof  = (mode_q == ModeD) && eof_q;
          if ((mode_q == ModeA) && needb_q) begin
            mode_d  = ModeB;
            needb_d = 1'b0;
            state_d = SLoad;
          end else begin
            state_d = SIdle;
          end
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      mode_q  <= ModeA;
      fw_q    <= WidthReset;
      fh_q    <= HeightReset;
      col_q   <= '0;
      row_q   <= '0;
      pend_q  <= '0;
      j_q     <= '0;
      tap_q   <= '0;
      needb_q <= 1'b0;
      eof_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      col_q   <= col_d;
      row_q   <= row_d;
      pend_q  <= pend_d;
      j_q     <= j_d;
      tap_q   <= tap_d;
      needb_q <= needb_d;
      eof_q   <= eof_d;
      if (cfg_we_i && (cfg_idx_i == CfgWidth)) begin
        fw_q <= cfg_data_i[CntW-1:0];
      end
      if (cfg_we_i && (cfg_idx_i == CfgHeight)) begin
        fh_q <= cfg_data_i[15:0];
      end
    end
  end

endmodule

// ===== src/rgbc_datapath.sv =====
module rgbc_datapath import rgbc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  in_word_t            in_data_i,
  input  cmd_t                cmd_i,
  output stat_t               stat_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output out_word_t           out_data_o
);

  logic [47:0]        kern_q [3];
  logic [15:0]        scale_q;
  logic [23:0]        pix_q;
  logic [47:0]        mem [MaxWidth];
  logic [47:0]        rdata_q;
  logic [23:0]        win_q [Taps];
  logic [23:0]        nb_q [Taps];
  logic signed [15:0] wt [Taps];
  logic signed [27:0] acc_q [3];
  logic signed [44:0] sp_q [3];
  logic signed [8:0]  px [3];
  logic signed [24:0] prod [3];
  logic [44:0]        mag [3];
  logic [7:0]         tr [3];
  logic [7:0]         q8 [3];
  logic [23:0]        older, newer;
  logic               out_valid_q;
  out_word_t          out_q;

  for (genvar h = 0; h < 3; h++) begin : g_wh
    for (genvar v = 0; v < 3; v++) begin : g_wv
      assign wt[h*3+v] = kern_q[h][16*v +: 16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kern_q[0] <= KernReset;
      kern_q[1] <= KernReset;
      kern_q[2] <= KernReset;
      scale_q   <= ScaleReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgKernLeft:  kern_q[0] <= cfg_data_i;
        CfgKernMid:   kern_q[1] <= cfg_data_i;
        CfgKernRight: kern_q[2] <= cfg_data_i;
        CfgScale:     scale_q   <= cfg_data_i[15:0];
        default:      ;
      endcase
    end
  end

  assign older = cmd_i.row_zero ? pix_q : rdata_q[23:0];
  assign newer = cmd_i.row_zero ? pix_q : rdata_q[47:24];

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[cmd_i.wr_addr] <= {pix_q, newer};
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[cmd_i.rd_addr];
    end
    if (cmd_i.pix_load) begin
      pix_q <= {in_data_i.blue, in_data_i.green, in_data_i.red};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Taps; i++) begin
        win_q[i] <= '0;
      end
    end else if (cmd_i.wr_en) begin
      for (int i = 0; i < 3; i++) begin
        if (cmd_i.col_zero) begin
          win_q[i*3+0] <= older;
          win_q[i*3+1] <= newer;
          win_q[i*3+2] <= pix_q;
        end else begin
          win_q[i]   <= win_q[3+i];
          win_q[3+i] <= win_q[6+i];
        end
      end
      if (!cmd_i.col_zero) begin
        win_q[6] <= older;
        win_q[7] <= newer;
        win_q[8] <= pix_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.nb_sel)
      NbWin: begin
        for (int i = 0; i < Taps; i++) begin
          nb_q[i] <= win_q[i];
        end
      end
      NbShift: begin
        // right edge: repeat the last column
        for (int i = 0; i < 3; i++) begin
          nb_q[i]   <= win_q[3+i];
          nb_q[3+i] <= win_q[6+i];
          nb_q[6+i] <= win_q[6+i];
        end
      end
      default: begin
        if (cmd_i.drd_load) begin
          // bottom edge: the newer row stands in for the row below
          for (int i = 0; i < 3; i++) begin
            if (cmd_i.drd_col == 2'(i)) begin
              nb_q[i*3+0] <= rdata_q[23:0];
              nb_q[i*3+1] <= rdata_q[47:24];
              nb_q[i*3+2] <= rdata_q[47:24];
            end
          end
        end
      end
    endcase
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      px[c]   = $signed({1'b0, nb_q[cmd_i.tap][8*c +: 8]});
      prod[c] = px[c] * wt[cmd_i.tap];
      mag[c]  = sp_q[c][44] ? 45'(-sp_q[c]) : sp_q[c];
      tr[c]   = mag[c][31:24];
      q8[c]   = sp_q[c][44] ? 8'(8'd0 - tr[c]) : tr[c];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      if (cmd_i.acc_clr) begin
        acc_q[c] <= '0;
      end else if (cmd_i.mac_en) begin
        acc_q[c] <= acc_q[c] + 28'(prod[c]);
      end
      if (cmd_i.scl_en) begin
        sp_q[c] <= acc_q[c] * $signed({1'b0, scale_q});
      end
    end
  end

  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.out_red      <= q8[0];
      out_q.out_green    <= q8[1];
      out_q.out_blue     <= q8[2];
      out_q.last_of_step <= cmd_i.out_last;
      out_q.end_of_frame <= cmd_i.out_eof;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== tb/sv/tb_rgb_convolution_3x3_clamped_top.sv =====
`timescale 1ns / 1ps

module tb_rgb_convolution_3x3_clamped_top;
  import rgbc_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = CfgKernLeft;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  in_word_t            in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_word_t           out_data_o;

  rgb_convolution_3x3_clamped_top u_top (.*);

  always #10 clk_i = ~clk_i;

  // mirror of the block's registers and state
  logic [47:0] kern_cols [3];
  logic [15:0] scale_q;
  logic [11:0] width_reg;
  logic [15:0] height_reg;
  logic [47:0] row_lines [MaxWidth];
  logic [23:0] win_taps [9];
  logic [23:0] nb_taps [9];
  int unsigned col_cnt, row_cnt, drain_left;

  in_word_t  pixel_words [$];
  out_word_t filtered_due [$];
  int        err_count = 0;
  int        random_items = 0;
  bit        calm = 1'b0;
  bit        hold_req = 1'b0;
  int        hold_left = 0;
  int        quiet_cycles = 0;

  function automatic logic [23:0] filter_taps();
    longint     acc, q, p, w;
    logic [23:0] res;
    for (int ch = 0; ch < 3; ch++) begin
      acc = 0;
      for (int h = 0; h < 3; h++) begin
        for (int v = 0; v < 3; v++) begin
          p = longint'(nb_taps[h*3+v][8*ch +: 8]);
          w = longint'($signed(kern_cols[h][16*v +: 16]));
          acc += p * w * longint'(scale_q);
        end
      end
      q = (acc < 0) ? -((-acc) >>> 24) : (acc >>> 24);
      res[8*ch +: 8] = q[7:0];
    end
    return res;
  endfunction

  function automatic void push_result(logic [23:0] rgb, logic last, logic eof);
    out_word_t o;
    o.out_red = rgb[7:0];
    o.out_green = rgb[15:8];
    o.out_blue = rgb[23:16];
    o.last_of_step = last;
    o.end_of_frame = eof;
    filtered_due.push_back(o);
  endfunction

  function automatic void predict_word(in_word_t w);
    int unsigned wd, ht, c, r, d, cl, cr;
    logic [23:0] pix, older, newer;
    logic [47:0] e;
    logic        lastcol;
    wd = (width_reg == 0) ? 1 : (width_reg > MaxWidth) ? MaxWidth : width_reg;
    ht = (height_reg == 0) ? 1 : height_reg;
    if (w.action) begin
      if (drain_left == 0) return;
      d = (col_cnt >= MaxWidth) ? MaxWidth - 1 : col_cnt;
      cl = (d != 0) ? d - 1 : d;
      cr = (d + 1 < wd && d + 1 < MaxWidth) ? d + 1 : d;
      for (int i = 0; i < 3; i++) begin
        e = row_lines[(i == 0) ? cl : (i == 1) ? d : cr];
        nb_taps[i*3+0] = e[23:0];
        nb_taps[i*3+1] = e[47:24];
        nb_taps[i*3+2] = e[47:24];
      end
      drain_left--;
      col_cnt++;
      if (drain_left == 0) col_cnt = 0;
      push_result(filter_taps(), 1'b1, drain_left == 0);
      return;
    end
    // a pixel drops whatever of the last row is still owed
    if (drain_left > 0) begin
      drain_left = 0;
      col_cnt = 0;
      row_cnt = 0;
    end
    c = (col_cnt >= MaxWidth) ? MaxWidth - 1 : col_cnt;
    r = row_cnt;
    pix = {w.blue, w.green, w.red};
    e = row_lines[c];
    older = e[23:0];
    newer = e[47:24];
    if (r == 0) begin
      older = pix;
      newer = pix;
      row_lines[c] = {pix, pix};
    end else begin
      row_lines[c] = {pix, newer};
    end
    if (c == 0) begin
      for (int i = 0; i < 3; i++) begin
        win_taps[i*3+0] = older;
        win_taps[i*3+1] = newer;
        win_taps[i*3+2] = pix;
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        win_taps[i] = win_taps[3+i];
        win_taps[3+i] = win_taps[6+i];
      end
      win_taps[6] = older;
      win_taps[7] = newer;
      win_taps[8] = pix;
    end
    lastcol = (c >= wd - 1);
    if (c != 0 && r >= 1) begin
      nb_taps = win_taps;
      push_result(filter_taps(), !lastcol, 1'b0);
    end
    if (lastcol && r >= 1) begin
      for (int i = 0; i < 3; i++) begin
        nb_taps[i] = win_taps[3+i];
        nb_taps[3+i] = win_taps[6+i];
        nb_taps[6+i] = win_taps[6+i];
      end
      push_result(filter_taps(), 1'b1, 1'b0);
    end
    if (lastcol) begin
      col_cnt = 0;
      if (r >= ht - 1) begin
        row_cnt = 0;
        drain_left = wd;
      end else begin
        row_cnt = r + 1;
      end
    end else begin
      col_cnt = c + 1;
    end
  endfunction

  // sender
  always @(posedge clk_i) begin
    bit fire;
    fire = in_valid_i && !in_stall_o;
    if (fire) begin
      predict_word(pixel_words.pop_front());
    end
    if (!in_valid_i || fire) begin
      if (pixel_words.size() > 0 && (calm || $urandom_range(99) >= 11)) begin
        in_valid_i <= 1'b1;
        in_data_i <= pixel_words[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver, checker and watchdog
  always @(posedge clk_i) begin
    out_word_t due;
    if (out_valid_o && !out_stall_i) begin
      if (filtered_due.size() == 0) begin
        $error("unexpected word red=%0d green=%0d blue=%0d", out_data_o.out_red,
               out_data_o.out_green, out_data_o.out_blue);
        err_count++;
      end else begin
        due = filtered_due.pop_front();
        if (out_data_o.out_red !== due.out_red) begin
          $error("out_red expected %0d got %0d", due.out_red, out_data_o.out_red);
          err_count++;
        end
        if (out_data_o.out_green !== due.out_green) begin
          $error("out_green expected %0d got %0d", due.out_green, out_data_o.out_green);
          err_count++;
        end
        if (out_data_o.out_blue !== due.out_blue) begin
          $error("out_blue expected %0d got %0d", due.out_blue, out_data_o.out_blue);
          err_count++;
        end
        if (out_data_o.last_of_step !== due.last_of_step) begin
          $error("last_of_step expected %0b got %0b", due.last_of_step,
                 out_data_o.last_of_step);
          err_count++;
        end
        if (out_data_o.end_of_frame !== due.end_of_frame) begin
          $error("end_of_frame expected %0b got %0b", due.end_of_frame,
                 out_data_o.end_of_frame);
          err_count++;
        end
      end
    end
    if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= 3000) begin
      $display("tb_rgb_convolution_3x3_clamped_top: errors");
      $finish;
    end
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_req) begin
      hold_req <= 1'b0;
      hold_left <= 400;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 11);
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [47:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CfgKernLeft:  kern_cols[0] = val;
      CfgKernMid:   kern_cols[1] = val;
      CfgKernRight: kern_cols[2] = val;
      CfgScale:     scale_q = val[15:0];
      CfgWidth:     width_reg = val[11:0];
      CfgHeight:    height_reg = val[15:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // wait until every word is taken and answered, then let the block go quiet
  task automatic settle();
    while (pixel_words.size() > 0 || in_valid_i || filtered_due.size() > 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    in_word_t w;
    w.action = 1'b0;
    w.red = r;
    w.green = g;
    w.blue = b;
    pixel_words.push_back(w);
  endtask

  task automatic send_drain();
    in_word_t w;
    w = in_word_t'({$urandom} & 25'h0ff_ffff);
    w.action = 1'b1;
    pixel_words.push_back(w);
  endtask

  function automatic logic [7:0] rand_comp();
    int k;
    k = $urandom_range(9);
    return (k == 0) ? 8'd0 : (k == 1) ? 8'd255 : 8'($urandom);
  endfunction

  task automatic send_rand_pixel();
    send_pixel(rand_comp(), rand_comp(), rand_comp());
  endtask

  initial begin
    int unsigned wd, ht, frames, n, phase;
    kern_cols[0] = KernReset;
    kern_cols[1] = KernReset;
    kern_cols[2] = KernReset;
    scale_q = ScaleReset;
    width_reg = WidthReset;
    height_reg = HeightReset;
    foreach (win_taps[i]) win_taps[i] = '0;
    foreach (row_lines[i]) row_lines[i] = '0;
    col_cnt = 0;
    row_cnt = 0;
    drain_left = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // extreme weights and full scale on a 4x3 frame
    write_reg(CfgKernLeft, 48'h8000_7fff_0100);
    write_reg(CfgKernMid, 48'h0100_ffff_7fff);
    write_reg(CfgKernRight, 48'h7fff_8000_0000);
    write_reg(CfgScale, 48'd65535);
    write_reg(CfgWidth, 48'd4);
    write_reg(CfgHeight, 48'd3);
    // hold the receiver off so the block fills and stalls its input
    hold_req = 1'b1;
    @(negedge clk_i);
    send_drain();
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_drain();
    repeat (8) send_rand_pixel();
    send_drain();
    send_drain();
    // a pixel while the last row is owed starts a fresh frame
    repeat (12) send_rand_pixel();
    repeat (5) send_drain();
    settle();

    // zero sizes act as one
    write_reg(CfgWidth, 48'd0);
    write_reg(CfgHeight, 48'd0);
    write_reg(CfgScale, 48'd0);
    @(negedge clk_i);
    send_pixel(8'd200, 8'd100, 8'd50);
    send_drain();
    settle();
    write_reg(CfgScale, 48'd32768);
    @(negedge clk_i);
    send_pixel(8'd255, 8'd1, 8'd128);
    send_drain();
    settle();

    // shrink the frame part way through
    write_reg(CfgWidth, 48'd8);
    write_reg(CfgHeight, 48'd4);
    @(negedge clk_i);
    repeat (12) send_rand_pixel();
    settle();
    write_reg(CfgWidth, 48'd3);
    write_reg(CfgHeight, 48'd2);
    @(negedge clk_i);
    repeat (7) send_rand_pixel();
    repeat (3) send_drain();
    settle();

    // fill every line store column that the random frames can reach
    write_reg(CfgWidth, 48'd12);
    write_reg(CfgHeight, 48'd1);
    @(negedge clk_i);
    repeat (12) send_rand_pixel();
    repeat (12) send_drain();
    settle();

    phase = 0;
    while (random_items < 1250) begin
      wd = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 10);
      ht = $urandom_range(0, 4);
      write_reg(CfgKernLeft, 48'({$urandom, $urandom}));
      write_reg(CfgKernMid, 48'({$urandom, $urandom}));
      write_reg(CfgKernRight, 48'({$urandom, $urandom}));
      n = $urandom_range(9);
      write_reg(CfgScale, (n == 0) ? 48'd65535 : (n == 1) ? 48'd0 : 48'($urandom));
      write_reg(CfgWidth, 48'(wd));
      write_reg(CfgHeight, 48'(ht));
      if (wd == 0) wd = 1;
      if (ht == 0) ht = 1;
      calm = (phase >= 20 && phase < 28);
      if (phase == 6 || phase == 40) hold_req = 1'b1;
      @(negedge clk_i);
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        for (int p = 0; p < wd * ht; p++) begin
          if ($urandom_range(99) < 4) send_drain();
          send_rand_pixel();
          random_items++;
        end
        // short drains leave pixels owed for the next frame to drop
        n = ($urandom_range(3) == 0) ? $urandom_range(wd) : wd + $urandom_range(2);
        repeat (n) send_drain();
        random_items += n;
      end
      settle();
      phase++;
    end
    calm = 1'b0;

    if (err_count == 0) begin
      $display("tb_rgb_convolution_3x3_clamped_top: clean");
    end else begin
      $display("tb_rgb_convolution_3x3_clamped_top: errors");
    end
    $finish;
  end

endmodule
